[rtl/s2f_pkg.sv]
// s2f_pkg: shared types, format codes and helpers of the sample to binary32 scaler
// no dependencies

package s2f_pkg;

  localparam int unsigned FMT_W = 3;

  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_U16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_U32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_F32 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_F64 = 3'd4;

  localparam logic [FMT_W-1:0] FMT_RESET = FMT_F32;

  localparam int unsigned REG_SAMPLE_FORMAT = 0;

  localparam int unsigned FLT_W = 32;
  localparam int unsigned EXP_W = 12;
  localparam int unsigned SIG_W = 53;

  localparam logic [FLT_W-1:0] QUIET_BIT = 32'h0040_0000;

  typedef struct packed {
    logic                     direct;
    logic [FLT_W-1:0]         bits;
    logic                     sign;
    logic signed [EXP_W-1:0]  expo;
    logic [SIG_W-1:0]         sig;
    logic                     last;
  } s2f_mid_t;

  // position of the highest set bit
  function automatic logic [4:0] lead_pos(input logic [23:0] w);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 24; i++) begin
      if (w[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

[rtl/s2f_sample_if.sv]
// s2f_sample_if: valid/ready channel carrying one raw sample per transaction
// no dependencies

interface s2f_sample_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_sample;
  logic        last_in;

  modport source (output valid, output raw_sample, output last_in, input ready);
  modport sink (input valid, input raw_sample, input last_in, output ready);
endinterface

[rtl/s2f_result_if.sv]
// s2f_result_if: valid/ready channel carrying one binary32 result per transaction
// no dependencies

interface s2f_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  logic        last_out;

  modport source (output valid, output float_bits, output last_out, input ready);
  modport sink (input valid, input float_bits, input last_out, output ready);
endinterface

[rtl/sample_to_float32_scaler.sv]
// sample_to_float32_scaler: top level, three register stages with valid/ready flow control
// depends on s2f_pkg, s2f_sample_if, s2f_result_if, s2f_cfg, s2f_scale, s2f_round
//
// usage
//   sample_i carries one raw sample (right aligned) and a last flag per transaction;
//   result_o returns its binary32 pattern and the same last flag, in order.
//   the format register (APB, address 0) picks uint8, uint16, uint32, float32 or
//   float64 samples; write it only while no transaction is in flight.
//   result_o.valid rises once the sample has passed an input register, a register
//   after the scale and binary64 rounding, and the result register.
//   throughput is one transaction per cycle while the receiver takes results; each stage
//   takes a new item when it is empty or its successor advances, so a stalled receiver
//   only holds the stages behind it and input is still taken until all three are full.
//   reset empties all stages and sets the format to float32.
//   result_o.valid stays high with stable payload until result_o.ready.

module sample_to_float32_scaler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  s2f_sample_if.sink          sample_i,
  s2f_result_if.source        result_o
);

  logic [s2f_pkg::FMT_W-1:0] fmt;

  logic                      s0_vld_q;
  logic [63:0]               s0_raw_q;
  logic                      s0_last_q;
  logic                      s1_vld_q;
  s2f_pkg::s2f_mid_t         s1_q;
  s2f_pkg::s2f_mid_t         s1_d;
  logic                      s2_vld_q;
  logic [31:0]               s2_bits_q;
  logic [31:0]               s2_bits_d;
  logic                      s2_last_q;

  logic                      s0_rdy;
  logic                      s1_rdy;
  logic                      s2_rdy;

  s2f_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt_o   (fmt)
  );

  s2f_scale u_scale (
    .fmt_i  (fmt),
    .raw_i  (s0_raw_q),
    .last_i (s0_last_q),
    .mid_o  (s1_d)
  );

  s2f_round u_round (
    .mid_i  (s1_q),
    .bits_o (s2_bits_d)
  );

  assign s2_rdy         = !s2_vld_q || result_o.ready;
  assign s1_rdy         = !s1_vld_q || s2_rdy;
  assign s0_rdy         = !s0_vld_q || s1_rdy;
  assign sample_i.ready = s0_rdy;

  assign result_o.valid      = s2_vld_q;
  assign result_o.float_bits = s2_bits_q;
  assign result_o.last_out   = s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s0_rdy) begin
        s0_vld_q <= sample_i.valid;
      end
      if (s1_rdy) begin
        s1_vld_q <= s0_vld_q;
      end
      if (s2_rdy) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && sample_i.valid) begin
      s0_raw_q  <= sample_i.raw_sample;
      s0_last_q <= sample_i.last_in;
    end
    if (s1_rdy && s0_vld_q) begin
      s1_q <= s1_d;
    end
    if (s2_rdy && s1_vld_q) begin
      s2_bits_q <= s2_bits_d;
      s2_last_q <= s1_q.last;
    end
  end

endmodule

[rtl/s2f_cfg.sv]
// s2f_cfg: APB register holding the sample format
// depends on s2f_pkg

module s2f_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [s2f_pkg::FMT_W-1:0] fmt_o
);

  logic [s2f_pkg::FMT_W-1:0] fmt_q;
  logic                      sel_fmt;

  assign sel_fmt = (32'(paddr[2]) == s2f_pkg::REG_SAMPLE_FORMAT);
  assign pready  = 1'b1;
  assign prdata  = sel_fmt ? 32'(fmt_q) : '0;
  assign fmt_o   = fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= s2f_pkg::FMT_RESET;
    end else if (psel && penable && pwrite && sel_fmt) begin
      fmt_q <= pwdata[s2f_pkg::FMT_W-1:0];
    end
  end

endmodule

[rtl/s2f_scale.sv]
// s2f_scale: unpacks a raw sample, applies the format scale and, for float64, rounds to binary64 precision
// depends on s2f_pkg

module s2f_scale (
  input  logic [s2f_pkg::FMT_W-1:0] fmt_i,
  input  logic [63:0]               raw_i,
  input  logic                      last_i,
  output s2f_pkg::s2f_mid_t         mid_o
);

  logic [7:0]         e32;
  logic [22:0]        f32;
  logic [10:0]        e64;
  logic [51:0]        f64;
  logic [23:0]        w;
  logic [4:0]         p;
  logic [23:0]        m24;
  logic [23:0]        m24n;
  logic signed [11:0] xin;
  logic [39:0]        p40;
  logic [52:0]        m53;
  logic [68:0]        p69;
  logic [52:0]        keep;
  logic               g;
  logic               st;
  logic               inc;
  logic [53:0]        r54;
  logic signed [11:0] x64;

  always_comb begin
    e32  = raw_i[30:23];
    f32  = raw_i[22:0];
    e64  = raw_i[62:52];
    f64  = raw_i[51:0];

    case (fmt_i)
      s2f_pkg::FMT_U8:  w = {8'b0, raw_i[7:0], 8'b0};
      s2f_pkg::FMT_U16: w = {8'b0, raw_i[15:0]};
      s2f_pkg::FMT_U32: w = {8'b0, raw_i[31:16]};
      default:          w = {1'b0, f32};
    endcase

    p    = s2f_pkg::lead_pos(w);
    m24  = w << (5'd23 - p);
    m24n = (e32 == 8'd0) ? m24 : {1'b1, f32};
    xin  = (e32 == 8'd0) ? ($signed({7'b0, p}) - 12'sd149)
                         : ($signed({4'b0, e32}) - 12'sd127);
    p40  = {m24n, 16'b0} - {16'b0, m24n};

    // binary64 product, then round to 53 bits
    m53  = {1'b1, f64};
    p69  = {m53, 16'b0} - {16'b0, m53};
    if (p69[68]) begin
      keep = p69[68:16];
      g    = p69[15];
      st   = |p69[14:0];
      x64  = $signed({1'b0, e64}) - 12'sd1007;
    end else begin
      keep = p69[67:15];
      g    = p69[14];
      st   = |p69[13:0];
      x64  = $signed({1'b0, e64}) - 12'sd1008;
    end
    inc  = g & (st | keep[0]);
    r54  = {1'b0, keep} + 54'(inc);

    mid_o        = '0;
    mid_o.last   = last_i;

    case (fmt_i)
      s2f_pkg::FMT_U8, s2f_pkg::FMT_U16, s2f_pkg::FMT_U32: begin
        if (w == '0) begin
          mid_o.direct = 1'b1;
        end else begin
          mid_o.expo = $signed({7'b0, p});
          mid_o.sig  = {m24, 29'b0};
        end
      end
      s2f_pkg::FMT_F64: begin
        mid_o.sign = raw_i[63];
        if (e64 == 11'h7FF) begin
          mid_o.direct = 1'b1;
          mid_o.bits   = (f64 != '0) ? {raw_i[63], 8'hFF, 1'b1, f64[50:29]}
                                     : {raw_i[63], 8'hFF, 23'b0};
        end else if (e64 == 11'd0) begin
          // subnormal inputs land far below the binary32 range
          mid_o.direct = 1'b1;
          mid_o.bits   = {raw_i[63], 31'b0};
        end else if (r54[53]) begin
          mid_o.expo = x64 + 12'sd1;
          mid_o.sig  = {1'b1, 52'b0};
        end else begin
          mid_o.expo = x64;
          mid_o.sig  = r54[52:0];
        end
      end
      default: begin
        mid_o.sign = raw_i[31];
        if (e32 == 8'hFF) begin
          mid_o.direct = 1'b1;
          mid_o.bits   = (f32 != '0) ? (raw_i[31:0] | s2f_pkg::QUIET_BIT)
                                     : {raw_i[31], 8'hFF, 23'b0};
        end else if (e32 == 8'd0 && f32 == '0) begin
          mid_o.direct = 1'b1;
          mid_o.bits   = {raw_i[31], 31'b0};
        end else if (p40[39]) begin
          mid_o.expo = xin + 12'sd16;
          mid_o.sig  = {p40, 13'b0};
        end else begin
          mid_o.expo = xin + 12'sd15;
          mid_o.sig  = {p40[38:0], 14'b0};
        end
      end
    endcase
  end

endmodule

[rtl/s2f_round.sv]
// s2f_round: rounds a normalized significand to a binary32 pattern, nearest even
// depends on s2f_pkg

module s2f_round (
  input  s2f_pkg::s2f_mid_t mid_i,
  output logic [31:0]       bits_o
);

  logic [7:0]         biased;
  logic               g;
  logic               st;
  logic               inc;
  logic [30:0]        rn;
  logic signed [11:0] shr12;
  logic [5:0]         shr;
  logic [108:0]       shifted;
  logic [23:0]        kept;
  logic               gs;
  logic               sts;
  logic               incs;
  logic [23:0]        mant;

  always_comb begin
    biased  = 8'(mid_i.expo + 12'sd127);
    g       = mid_i.sig[28];
    st      = |mid_i.sig[27:0];
    inc     = g & (st | mid_i.sig[29]);
    rn      = {biased, mid_i.sig[51:29]} + 31'(inc);

    // subnormal range
    shr12   = -12'sd97 - mid_i.expo;
    shr     = (shr12 > 12'sd54) ? 6'd54 : shr12[5:0];
    shifted = {mid_i.sig, 56'b0} >> shr;
    kept    = shifted[79:56];
    gs      = shifted[55];
    sts     = |shifted[54:0];
    incs    = gs & (sts | kept[0]);
    mant    = kept + 24'(incs);

    if (mid_i.direct) begin
      bits_o = mid_i.bits;
    end else if (mid_i.expo > 12'sd127) begin
      bits_o = {mid_i.sign, 8'hFF, 23'b0};
    end else if (mid_i.expo >= -12'sd126) begin
      bits_o = {mid_i.sign, rn};
    end else begin
      bits_o = {mid_i.sign, 7'b0, mant};
    end
  end

endmodule

[rtl/s2f_checker.sv]
// s2f_checker: port-level assertions for sample_to_float32_scaler, bound to the top level
// depends on sample_to_float32_scaler

module s2f_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_bits_i,
  input logic        out_last_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_bits_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // an empty output stage never blocks the input
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // with the receiver taking results, an accepted sample passes the input, scale and result registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after three cycles");

endmodule

bind sample_to_float32_scaler s2f_checker u_s2f_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_bits_i  (result_o.float_bits),
  .out_last_i  (result_o.last_out)
);

[verif/tb.sv]
// tb: self-checking testbench of sample_to_float32_scaler, one binary32 result per sample
// drives samples over s2f_sample_if, checks s2f_result_if against an in-line predictor
// depends on s2f_pkg, s2f_sample_if, s2f_result_if and the rtl of the scaler

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 8;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } float_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  s2f_sample_if sample_if ();
  s2f_result_if result_if ();

  float_exp_t     float_q[$];
  logic [s2f_pkg::FMT_W-1:0] cur_fmt;
  int unsigned    src_idle;
  int unsigned    snk_stall;
  int unsigned    hold_req;
  int unsigned    hold_left;
  int unsigned    mismatches;
  int unsigned    quiet_cycles;

  sample_to_float32_scaler DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_i (sample_if.sink),
    .result_o (result_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // value = mant * 2^e2, rounded to binary32, nearest even
  function automatic logic [31:0] round_to_f32(input logic sgn, input logic [63:0] mant,
                                               input int e2);
    logic [127:0] wide;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] half;
    logic [31:0]  base;
    int           p;
    int           lead;
    int           sh;
    if (mant == '0) begin
      return {sgn, 31'b0};
    end
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (mant[i]) begin
        p = i;
      end
    end
    lead = p + e2;
    if (lead > 127) begin
      return {sgn, 8'hFF, 23'b0};
    end
    sh = p - 23;
    if (lead < -126) begin
      sh = sh + (-126 - lead);
    end
    wide = 128'(mant);
    if (sh <= 0) begin
      q = wide << (-sh);
    end else begin
      if (sh > 126) begin
        sh = 126;
      end
      q = wide >> sh;
      rem = wide & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
        q = q + 128'd1;
      end
    end
    if (lead >= -126) begin
      base = 32'((lead + 126) << 23) + q[31:0];
    end else begin
      base = q[31:0];
    end
    if (base >= 32'h7F80_0000) begin
      base = 32'h7F80_0000;
    end
    return {sgn, base[30:0]};
  endfunction

  function automatic logic [31:0] scale_sample(input logic [s2f_pkg::FMT_W-1:0] fmt,
                                               input logic [63:0] raw);
    logic [63:0] prod;
    logic [31:0] f;
    case (fmt)
      s2f_pkg::FMT_U8: begin
        return round_to_f32(1'b0, {56'b0, raw[7:0]}, 8);
      end
      s2f_pkg::FMT_U16: begin
        return round_to_f32(1'b0, {48'b0, raw[15:0]}, 0);
      end
      s2f_pkg::FMT_U32: begin
        return round_to_f32(1'b0, {48'b0, raw[31:16]}, 0);
      end
      s2f_pkg::FMT_F64: begin
        if (raw[62:52] == 11'h7FF && raw[51:0] != '0) begin
          return {raw[63], 8'hFF, 1'b1, raw[50:29]};
        end
        prod = $realtobits($bitstoreal(raw) * 65535.0);
        if (prod[62:52] == 11'h7FF) begin
          return {prod[63], 8'hFF, 23'b0};
        end else if (prod[62:52] == '0) begin
          return round_to_f32(prod[63], {12'b0, prod[51:0]}, -1074);
        end
        return round_to_f32(prod[63], {11'b0, 1'b1, prod[51:0]}, int'(prod[62:52]) - 1075);
      end
      default: begin
        f = raw[31:0];
        if (f[30:23] == 8'hFF) begin
          return (f[22:0] != '0) ? (f | s2f_pkg::QUIET_BIT) : {f[31], 8'hFF, 23'b0};
        end else if (f[30:23] == '0) begin
          return round_to_f32(f[31], 64'(f[22:0]) * 64'd65535, -149);
        end
        return round_to_f32(f[31], 64'({1'b1, f[22:0]}) * 64'd65535, int'(f[30:23]) - 150);
      end
    endcase
  endfunction

  task automatic send_sample(input logic [63:0] raw, input logic last);
    logic fire;
    while ($urandom_range(99) < src_idle) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.raw_sample <= raw;
    sample_if.last_in    <= last;
    do begin
      @(negedge clk_i);
      fire = sample_if.valid && sample_if.ready;
      if (fire) begin
        float_q.push_back('{bits: scale_sample(cur_fmt, raw), last: last});
      end
      @(posedge clk_i);
    end while (!fire);
  endtask

  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (float_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_format(input logic [s2f_pkg::FMT_W-1:0] fmt);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(s2f_pkg::REG_SAMPLE_FORMAT * 4);
    pwdata  <= 32'(fmt);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_fmt = fmt;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_sample(input logic [s2f_pkg::FMT_W-1:0] fmt);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (fmt == s2f_pkg::FMT_F64) begin
      case ($urandom_range(4))
        1: r[62:52] = 11'($urandom_range(850, 890));
        2: r[62:52] = 11'($urandom_range(1125, 1150));
        3: r[62:52] = 11'($urandom_range(2040, 2047));
        4: r[62:52] = 11'($urandom_range(1000, 1050));
        default: ;
      endcase
    end else if (fmt != s2f_pkg::FMT_U8 && fmt != s2f_pkg::FMT_U16
                 && fmt != s2f_pkg::FMT_U32) begin
      case ($urandom_range(3))
        1: r[30:23] = 8'($urandom_range(0, 8));
        2: r[30:23] = 8'($urandom_range(230, 255));
        3: r[30:23] = 8'($urandom_range(100, 160));
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic test_reset_format();
    logic [31:0] vals[12];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
             32'h7F80_0001, 32'hFFA0_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF,
             32'h3F80_0000, 32'h4780_0080};
    foreach (vals[i]) begin
      send_sample({32'hFFFF_FFFF, vals[i]}, 1'($urandom));
    end
  endtask

  task automatic test_integer_extremes();
    write_format(s2f_pkg::FMT_U8);
    send_sample(64'h0, 1'b0);
    send_sample('1, 1'b1);
    write_format(s2f_pkg::FMT_U16);
    send_sample(64'hFFFF_FFFF_FFFF_0000, 1'b0);
    send_sample('1, 1'b1);
    write_format(s2f_pkg::FMT_U32);
    send_sample(64'hFFFF_FFFF_0000_FFFF, 1'b0);
    send_sample('1, 1'b1);
  endtask

  task automatic test_float64_cases();
    logic [63:0] vals[8];
    vals = '{64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001, 64'h7FF0_0000_0000_0000,
             64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
             64'h8000_0000_0000_0000, 64'h3881_0000_2000_0000};
    write_format(s2f_pkg::FMT_F64);
    foreach (vals[i]) begin
      send_sample(vals[i], 1'($urandom));
    end
  endtask

  task automatic test_random_formats();
    int unsigned idle_src[4];
    int unsigned idle_snk[4];
    idle_src = '{0, 72, 0, 9};
    idle_snk = '{0, 0, 72, 9};
    for (int f = 0; f < 8; f++) begin
      write_format(s2f_pkg::FMT_W'(f));
      for (int ph = 0; ph < 4; ph++) begin
        src_idle  = idle_src[ph];
        snk_stall = idle_snk[ph];
        repeat (50) send_sample(random_sample(s2f_pkg::FMT_W'(f)), 1'($urandom));
      end
    end
    src_idle  = 0;
    snk_stall = 0;
  endtask

  task automatic test_backpressure();
    write_format(s2f_pkg::FMT_F64);
    hold_req = 300;
    repeat (40) send_sample(random_sample(s2f_pkg::FMT_F64), 1'($urandom));
    write_format(s2f_pkg::FMT_F32);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(negedge clk_i) begin
    float_exp_t want;
    if (result_if.valid && result_if.ready) begin
      if (float_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: float_bits %h last_out %b",
                   result_if.float_bits, result_if.last_out);
        end
      end else begin
        want = float_q.pop_front();
        if (result_if.float_bits !== want.bits || result_if.last_out !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: float_bits exp %h got %h, last_out exp %b got %b",
                     want.bits, result_if.float_bits, want.last, result_if.last_out);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
        || rst_ni !== 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    sample_if.valid      <= 1'b0;
    sample_if.raw_sample <= '0;
    sample_if.last_in    <= 1'b0;
    cur_fmt      = s2f_pkg::FMT_RESET;
    src_idle     = 0;
    snk_stall    = 0;
    hold_req     = 0;
    hold_left    = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_format();
    test_integer_extremes();
    test_float64_cases();
    test_random_formats();
    test_backpressure();
    drain_results();
    if (mismatches == 0 && float_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
